// ===== design/sfacs_pkg.sv =====
// shared types and constants for the spi flash array command sequencer
`default_nettype none

package sfacs_pkg;

  // request kinds
  typedef enum logic [2:0] {
    FUNC_READ    = 3'd0,
    FUNC_PROGRAM = 3'd1,
    FUNC_ERASE4K = 3'd2,
    FUNC_ERASE64 = 3'd3,
    FUNC_END     = 3'd4
  } func_t;

  // chip type codes
  localparam logic [2:0] TypeAbsent = 3'd0;
  localparam logic [2:0] Type8mA    = 3'd1;
  localparam logic [2:0] TypeExtA   = 3'd2;
  localparam logic [2:0] Type16m    = 3'd3;
  localparam logic [2:0] Type8mB    = 3'd4;
  localparam logic [2:0] TypeExtB   = 3'd5;
  localparam logic [2:0] TypeWide   = 3'd6;

  // spi opcodes
  localparam logic [7:0] OpWren     = 8'h06;
  localparam logic [7:0] OpWrdi     = 8'h04;
  localparam logic [7:0] OpWrExtAdr = 8'hC5;
  localparam logic [7:0] OpRead3    = 8'h0B;
  localparam logic [7:0] OpRead4    = 8'h0C;
  localparam logic [7:0] OpProg3    = 8'h02;
  localparam logic [7:0] OpProg4    = 8'h12;
  localparam logic [7:0] OpErase4k3 = 8'h20;
  localparam logic [7:0] OpErase4k4 = 8'h21;
  localparam logic [7:0] OpErase643 = 8'hD8;
  localparam logic [7:0] OpErase644 = 8'hDC;
  localparam logic [7:0] PadByte    = 8'h00;

  localparam int NumRegs  = 7;   // chip type registers
  localparam int MaxBytes = 10;  // bytes per request, upper bound
  localparam int CntW     = 4;   // holds MaxBytes
  localparam int AddrW    = 28;
  localparam int LocalW   = 25;  // largest chip is 2^25 bytes
  localparam int UnitW    = 6;   // sizes in units of 2^23, sum of up to eight chips

  // chip size in units of 2^23 bytes
  function automatic logic [2:0] size_units(input logic [2:0] t);
    logic [2:0] u;
    case (t)
      Type8mA, Type8mB:             u = 3'd1;
      Type16m:                      u = 3'd2;
      TypeExtA, TypeExtB, TypeWide: u = 3'd4;
      default:                      u = 3'd0;
    endcase
    return u;
  endfunction

endpackage

`default_nettype wire

// ===== design/spi_flash_array_command_sequencer_unit.sv =====
// spi flash array command sequencer: address map and spi command header bytes
//
//  channel | dir | handshake           | payload
//  in_     | in  | in_tvalid/in_tready  | tdata array_address, tuser func
//  out_    | out | out_tvalid/out_tready| tdata byte/chip/frame marks, tuser error, tlast
//  cfg_    | in  | apb, pready tied high| chip type registers at 4*i
//
// a request is held in an input register, mapped onto a chip and expanded into its
// byte list in one pass, then loaded into the result register; the result register sends
// one byte per cycle unless stalled, 1 to 9 bytes per request, so the output side sets
// the rate. the next request is decoded while the current one drains: no gap between
// requests. first byte follows the input and result registers. reset clears the valid
// flags and type registers; an out_tready stall holds the byte and backs up the input.
`default_nettype none

module spi_flash_array_command_sequencer_unit #(
  parameter int NUM_CHIPS = 7
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input stream
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  input  wire logic [31:0] in_tdata,   // [27:0] array_address, [31:28] zero
  input  wire logic [2:0]  in_tuser,   // [2:0] func
  // result stream
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  output      logic [15:0] out_tdata,  // [7:0] spi_byte, [10:8] chip_index,
                                       // [11] frame_start, [12] frame_end, [15:13] zero
  output      logic [0:0]  out_tuser,  // [0] range_error
  output      logic        out_tlast,
  // configuration
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [4:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output      logic [31:0] cfg_prdata,
  output      logic        cfg_pready
);

  import sfacs_pkg::*;

  // configuration registers
  logic [2:0] type_r [NUM_CHIPS];
  logic [2:0] reg_idx;
  logic       cfg_wr;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[4:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_CHIPS; i++) begin
      if (!rst_n) begin
        type_r[i] <= TypeAbsent;
      end else if (cfg_wr && (int'(reg_idx) == i) && (i < NumRegs)) begin
        type_r[i] <= cfg_pwdata[2:0];
      end
    end
  end

  always_comb begin
    cfg_prdata = '0;
    for (int i = 0; i < NUM_CHIPS; i++) begin
      if ((int'(reg_idx) == i) && (i < NumRegs)) begin
        cfg_prdata = {29'd0, type_r[i]};
      end
    end
  end

  // input register
  logic             a_valid_r;
  logic [2:0]       a_func_r;
  logic [AddrW-1:0] a_addr_r;
  logic             a_pop;
  logic             a_drop;
  logic             h_free;

  // result register
  logic                         h_valid_r;
  logic [MaxBytes-1:0][7:0]     h_byte_r;
  logic [MaxBytes-1:0]          h_fs_r;
  logic [MaxBytes-1:0]          h_fe_r;
  logic                         h_err_r;
  logic [2:0]                   h_chip_r;
  logic [CntW-1:0]              h_cnt_r;
  logic [CntW-1:0]              idx_r;
  logic                         h_last;
  logic                         out_fire;

  assign a_drop    = a_func_r > FUNC_END;
  assign a_pop     = a_valid_r && (a_drop || h_free);
  assign in_tready = !a_valid_r || a_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_tready) begin
      a_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      a_func_r <= in_tuser;
      a_addr_r <= in_tdata[AddrW-1:0];
    end
  end

  // chip mapping: chips lie end to end, sizes are multiples of 2^23
  logic [4:0]        a_hi;
  logic [UnitW-1:0]  acc;
  logic [UnitW-1:0]  start;
  logic [UnitW-1:0]  hi_diff;
  logic              found;
  logic [2:0]        sel_chip;
  logic [2:0]        sel_type;
  logic [LocalW-1:0] loc;
  logic              ext;
  logic              wide;
  logic              is_read;
  logic              is_end;
  logic              close;
  logic [7:0]        op;
  logic [7:0]        adr3;
  logic [CntW-1:0]   pre;
  logic [CntW-1:0]   rel;

  logic [MaxBytes-1:0][7:0] seq_byte_nxt;
  logic [MaxBytes-1:0]      seq_fs_nxt;
  logic [MaxBytes-1:0]      seq_fe_nxt;
  logic [CntW-1:0]          seq_cnt_nxt;

  assign a_hi = a_addr_r[AddrW-1:23];

  always_comb begin
    acc      = '0;
    start    = '0;
    found    = 1'b0;
    sel_chip = '0;
    sel_type = TypeAbsent;
    for (int i = 0; i < NUM_CHIPS; i++) begin
      if (!found && ({1'b0, a_hi} < (acc + {3'd0, size_units(type_r[i])}))) begin
        found    = 1'b1;
        sel_chip = 3'(i);
        sel_type = type_r[i];
        start    = acc;
      end
      acc = acc + {3'd0, size_units(type_r[i])};
    end
  end

  assign hi_diff = {1'b0, a_hi} - start;
  assign loc     = {hi_diff[1:0], a_addr_r[22:0]};
  assign ext     = (sel_type == TypeExtA) || (sel_type == TypeExtB);
  assign wide    = sel_type == TypeWide;
  assign is_read = a_func_r == FUNC_READ;
  assign is_end  = a_func_r == FUNC_END;
  assign close   = (a_func_r == FUNC_ERASE4K) || (a_func_r == FUNC_ERASE64);
  assign adr3    = {7'd0, loc[24]};
  assign pre     = ext ? CntW'(3) : '0;

  always_comb begin
    case (a_func_r)
      FUNC_READ:    op = wide ? OpRead4 : OpRead3;
      FUNC_PROGRAM: op = wide ? OpProg4 : OpProg3;
      FUNC_ERASE4K: op = wide ? OpErase4k4 : OpErase4k3;
      default:      op = wide ? OpErase644 : OpErase643;
    endcase
  end

  // byte list: optional prefix, enable/disable, opcode, address, pad
  always_comb begin
    rel = '0;
    for (int j = 0; j < MaxBytes; j++) begin
      seq_byte_nxt[j] = PadByte;
      seq_fs_nxt[j]   = 1'b0;
      seq_fe_nxt[j]   = 1'b0;
      if (ext && (j < 3)) begin
        case (j)
          0: begin
            seq_byte_nxt[j] = OpWren;
            seq_fs_nxt[j]   = 1'b1;
            seq_fe_nxt[j]   = 1'b1;
          end
          1: begin
            seq_byte_nxt[j] = OpWrExtAdr;
            seq_fs_nxt[j]   = 1'b1;
          end
          default: begin
            seq_byte_nxt[j] = is_end ? PadByte : adr3;
            seq_fe_nxt[j]   = 1'b1;
          end
        endcase
      end else begin
        rel = CntW'(j) - pre;
        case (rel)
          4'd0: begin
            seq_byte_nxt[j] = (is_end || is_read) ? OpWrdi : OpWren;
            seq_fs_nxt[j]   = 1'b1;
            seq_fe_nxt[j]   = 1'b1;
          end
          4'd1: begin
            seq_byte_nxt[j] = op;
            seq_fs_nxt[j]   = 1'b1;
          end
          4'd2: seq_byte_nxt[j] = wide ? adr3 : loc[23:16];
          4'd3: seq_byte_nxt[j] = wide ? loc[23:16] : loc[15:8];
          4'd4: begin
            seq_byte_nxt[j] = wide ? loc[15:8] : loc[7:0];
            seq_fe_nxt[j]   = !wide && close;
          end
          4'd5: begin
            seq_byte_nxt[j] = wide ? loc[7:0] : PadByte;
            seq_fe_nxt[j]   = wide && close;
          end
          default: seq_byte_nxt[j] = PadByte;
        endcase
      end
    end
    // out of range: one all-zero byte with the error flag
    if (!found) begin
      seq_byte_nxt[0] = PadByte;
      seq_fs_nxt[0]   = 1'b0;
      seq_fe_nxt[0]   = 1'b0;
    end
  end

  always_comb begin
    if (!found) begin
      seq_cnt_nxt = CntW'(1);
    end else if (is_end) begin
      seq_cnt_nxt = pre + CntW'(1);
    end else begin
      seq_cnt_nxt = pre + (wide ? CntW'(6) : CntW'(5)) + (is_read ? CntW'(1) : CntW'(0));
    end
  end

  // result side
  assign out_fire = out_tvalid && out_tready;
  assign h_last   = CntW'(idx_r + CntW'(1)) == h_cnt_r;
  assign h_free   = !h_valid_r || (out_fire && h_last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_valid_r <= 1'b0;
      idx_r     <= '0;
    end else if (h_free) begin
      h_valid_r <= a_pop && !a_drop;
      idx_r     <= '0;
    end else if (out_fire) begin
      idx_r <= idx_r + CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (h_free && a_pop && !a_drop) begin
      h_byte_r <= seq_byte_nxt;
      h_fs_r   <= seq_fs_nxt;
      h_fe_r   <= seq_fe_nxt;
      h_err_r  <= !found;
      h_chip_r <= found ? sel_chip : 3'd0;
      h_cnt_r  <= seq_cnt_nxt;
    end
  end

  assign out_tvalid   = h_valid_r;
  assign out_tdata    = {3'd0, h_fe_r[idx_r], h_fs_r[idx_r], h_chip_r, h_byte_r[idx_r]};
  assign out_tuser[0] = h_err_r;
  assign out_tlast    = h_last;

`ifndef SYNTHESIS
  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    h_valid_r |-> (idx_r < h_cnt_r))
    else $error("byte index past end of request");

  a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && h_err_r) |-> (out_tlast && (out_tdata == 16'd0)))
    else $error("range error result is not a single blank byte");

  a_first_opens_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !h_err_r && (idx_r == '0)) |-> out_tdata[11])
    else $error("first byte of request does not open a frame");

  a_no_gap_in_request: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && !out_tlast) |=> out_tvalid)
    else $error("request bytes interrupted");
`endif

endmodule

`default_nettype wire
